// ===== design/assert_macros.svh =====
// Assertion helpers used by binary_field_inverter_163.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/bfi_pkg.sv =====
`default_nettype none

package bfi_pkg;

	localparam int WORD_W = 64;
	localparam int HIGH_W = 35;
	localparam int ELEM_W = 163;
	// The remainders carry one more bit so that the polynomial itself fits.
	localparam int WORK_W = 164;

	// x^163 + x^7 + x^6 + x^3 + 1
	localparam logic [WORK_W-1:0] POLY = {1'b1, 155'd0, 8'hc9};
	localparam logic [WORK_W-1:0] ONE  = {{(WORK_W-1){1'b0}}, 1'b1};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_ADD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic ack;
	} ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} status_t;

endpackage

`default_nettype wire

// ===== design/bfi_euclid.sv =====
`default_nettype none

module bfi_euclid (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bfi_pkg::ctl_t             ctl,
	input  wire logic [bfi_pkg::ELEM_W-1:0] elem,
	output bfi_pkg::status_t               status,
	output logic [bfi_pkg::ELEM_W-1:0]     inv
);

	bfi_pkg::state_t state_q;
	bfi_pkg::state_t state_d;

	logic [bfi_pkg::WORK_W-1:0] u_q;
	logic [bfi_pkg::WORK_W-1:0] v_q;
	logic [bfi_pkg::WORK_W-1:0] b_q;
	logic [bfi_pkg::WORK_W-1:0] c_q;
	logic                       lt_q;
	logic                       zero_q;

	logic                       u_nz;
	logic                       u_one;
	logic [bfi_pkg::WORK_W-1:0] b_odd_fix;
	logic [bfi_pkg::WORK_W-1:0] b_half;
	logic [bfi_pkg::WORK_W-1:0] u_sum;
	logic [bfi_pkg::WORK_W-1:0] cmp_rhs;
	logic                       u_lt;
	logic                       do_swap;

	assign u_nz      = |u_q;
	assign u_one     = (u_q == bfi_pkg::ONE);
	assign b_odd_fix = b_q[0] ? (b_q ^ bfi_pkg::POLY) : b_q;
	assign b_half    = b_odd_fix >> 1;
	assign u_sum     = u_q ^ v_q;
	// deg(u) < deg(v) exactly when u < v and u < (u ^ v); the first half is
	// taken in the cycle before, so the shared comparator is used once a cycle.
	assign cmp_rhs   = (state_q == bfi_pkg::ST_ADD) ? u_sum : v_q;
	assign u_lt      = (u_q < cmp_rhs);
	assign do_swap   = lt_q && u_lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfi_pkg::ST_IDLE: begin
				if (ctl.start) begin
					state_d = bfi_pkg::ST_SHIFT;
				end
			end
			bfi_pkg::ST_SHIFT: begin
				if (!u_q[0] && u_nz) begin
					state_d = bfi_pkg::ST_SHIFT;
				end else if (u_one || !u_nz) begin
					state_d = bfi_pkg::ST_DONE;
				end else begin
					state_d = bfi_pkg::ST_ADD;
				end
			end
			bfi_pkg::ST_ADD: begin
				state_d = bfi_pkg::ST_SHIFT;
			end
			bfi_pkg::ST_DONE: begin
				if (ctl.ack) begin
					state_d = bfi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bfi_pkg::ST_IDLE: begin
				if (ctl.start) begin
					u_q    <= {1'b0, elem};
					v_q    <= bfi_pkg::POLY;
					b_q    <= bfi_pkg::ONE;
					c_q    <= '0;
					zero_q <= (elem == '0);
				end
			end
			bfi_pkg::ST_SHIFT: begin
				if (!u_q[0] && u_nz) begin
					u_q <= u_q >> 1;
					b_q <= b_half;
				end else begin
					lt_q <= u_lt;
				end
			end
			bfi_pkg::ST_ADD: begin
				// The new u is u ^ v whether or not the pair is swapped.
				u_q <= u_sum;
				b_q <= b_q ^ c_q;
				if (do_swap) begin
					v_q <= u_q;
					c_q <= b_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign status.busy = (state_q != bfi_pkg::ST_IDLE);
	assign status.done = (state_q == bfi_pkg::ST_DONE);
	assign status.zero = zero_q;
	assign inv         = zero_q ? '0 : b_q[bfi_pkg::ELEM_W-1:0];

endmodule

`default_nettype wire

// ===== design/binary_field_inverter_163.sv =====
// Channel  Direction  Handshake            Payload
// in       to block   in_valid / in_stall  elem_low, elem_mid, elem_high
// out      from block out_valid / out_stall inv_low, inv_mid, inv_high, zero_input
//
// One word at a time: a shift step divides u by x in the shift state, while an add
// step compares in the shift state and then adds in the add state; a word needs at
// most 325 shifts and never more adds than shifts.
// Reset clears the sequencer and the output valid; the data registers are not reset.
// A finished word sits in the output register; the next word can be accepted in the cycle
// after the load; the core holds its result only while that register is full and stalled.
`default_nettype none

`include "assert_macros.svh"

module binary_field_inverter_163 (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [bfi_pkg::WORD_W-1:0] elem_low,
	input  wire logic [bfi_pkg::WORD_W-1:0] elem_mid,
	input  wire logic [bfi_pkg::HIGH_W-1:0] elem_high,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [bfi_pkg::WORD_W-1:0]      inv_low,
	output logic [bfi_pkg::WORD_W-1:0]      inv_mid,
	output logic [bfi_pkg::HIGH_W-1:0]      inv_high,
	output logic                            zero_input
);

	bfi_pkg::ctl_t              ctl;
	bfi_pkg::status_t           status;
	logic [bfi_pkg::ELEM_W-1:0] core_inv;
	logic                       out_valid_q;
	logic [bfi_pkg::ELEM_W-1:0] inv_q;
	logic                       zero_q;
	logic                       load_out;

	assign in_stall  = status.busy;
	assign ctl.start = in_valid && !status.busy;
	assign ctl.ack   = !out_valid_q || !out_stall;
	assign load_out  = status.done && ctl.ack;

	bfi_euclid u_euclid (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.elem   ({elem_high, elem_mid, elem_low}),
		.status (status),
		.inv    (core_inv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			inv_q  <= core_inv;
			zero_q <= status.zero;
		end
	end

	assign out_valid  = out_valid_q;
	assign inv_low    = inv_q[bfi_pkg::WORD_W-1:0];
	assign inv_mid    = inv_q[2*bfi_pkg::WORD_W-1:bfi_pkg::WORD_W];
	assign inv_high   = inv_q[bfi_pkg::ELEM_W-1:2*bfi_pkg::WORD_W];
	assign zero_input = zero_q;

	// An accepted word keeps the core busy in the next cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, ctl.start, status.busy)
	// A finished result that cannot be moved out is held, not dropped.
	`ASSERT_NEXT(a_done_held, clk, arst_n, status.done && !ctl.ack, status.done)
	// A zero element always comes back as a zero result.
	`ASSERT_SAME(a_zero_result, clk, arst_n, out_valid_q && zero_q, inv_q == '0)

endmodule

`default_nettype wire
